FILE: sv/rid_pkg.sv
// Package for the restoring integer divider: widths, mode codes and channel payload types.
`default_nettype none

package rid_pkg;

	// Width of the operand and result fields on the ports.
	localparam int FIELD_W = 64;

	// Datapath width of the wide modes; the narrow modes use half of it.
	localparam int WIDTH  = 64;
	localparam int DIV_W  = (WIDTH > FIELD_W) ? FIELD_W : WIDTH;
	localparam int HALF_W = DIV_W / 2;

	localparam logic [DIV_W-1:0] MASK_WIDE   = {DIV_W{1'b1}};
	localparam logic [DIV_W-1:0] MASK_NARROW = DIV_W'({HALF_W{1'b1}});

	// Operation modes.
	localparam logic [1:0] MODE_U_NARROW = 2'd0;
	localparam logic [1:0] MODE_S_NARROW = 2'd1;
	localparam logic [1:0] MODE_U_WIDE   = 2'd2;
	localparam logic [1:0] MODE_S_WIDE   = 2'd3;

	typedef struct packed {
		logic [1:0]         mode;
		logic [FIELD_W-1:0] dividend;
		logic [FIELD_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic [FIELD_W-1:0] quotient;
		logic [FIELD_W-1:0] remainder;
		logic               divide_by_zero;
	} div_rsp_t;

endpackage

`default_nettype wire

FILE: sv/restoring_integer_divider.sv
// Restoring integer divider: fully pipelined, one quotient bit per stage.
// A request passes one operand stage, DIV_W divide steps and one output register.
// Throughput: one request per cycle while the skid entry is empty;
// each divide step stage holds one DIV_W+1 bit subtract.
// A two-entry output (register plus skid) lets requests enter while a response waits.
// Reset: arst_n clears all valid bits asynchronously; no response is pending after reset.
`default_nettype none

module restoring_integer_divider import rid_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  div_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output div_rsp_t rsp
);

	// Per-stage payload. qa starts out as the dividend magnitude; each step shifts
	// one dividend bit out of the top and one quotient bit in at the bottom.
	typedef struct packed {
		logic [DIV_W-1:0] rem;
		logic [DIV_W-1:0] qa;
		logic [DIV_W-1:0] dsor;
		logic             neg_q;
		logic             neg_r;
		logic             wide;
		logic             dbz;
	} stage_t;

	// Pipeline advances as a whole; it only freezes while the skid entry is full.
	logic advance;

	// ------------------------------------------------------------------
	// Operand stage: select width, take magnitudes, flag a zero divisor.
	// ------------------------------------------------------------------
	logic             wide_in;
	logic             sgn_in;
	logic [DIV_W-1:0] msk_in;
	logic [DIV_W-1:0] a_in;
	logic [DIV_W-1:0] b_in;
	logic             neg_a;
	logic             neg_b;
	stage_t           prep;

	assign wide_in = (req.mode == MODE_U_WIDE) || (req.mode == MODE_S_WIDE);
	assign sgn_in  = (req.mode == MODE_S_NARROW) || (req.mode == MODE_S_WIDE);
	assign msk_in  = wide_in ? MASK_WIDE : MASK_NARROW;
	assign a_in    = req.dividend[DIV_W-1:0] & msk_in;
	assign b_in    = req.divisor[DIV_W-1:0] & msk_in;
	assign neg_a   = sgn_in && (wide_in ? a_in[DIV_W-1] : a_in[HALF_W-1]);
	assign neg_b   = sgn_in && (wide_in ? b_in[DIV_W-1] : b_in[HALF_W-1]);

	always_comb begin
		prep       = '0;
		prep.rem   = '0;
		prep.qa    = neg_a ? ((~a_in + DIV_W'(1)) & msk_in) : a_in;
		prep.dsor  = neg_b ? ((~b_in + DIV_W'(1)) & msk_in) : b_in;
		prep.neg_q = neg_a ^ neg_b;
		prep.neg_r = neg_a;
		prep.wide  = wide_in;
		prep.dbz   = (b_in == '0);
	end

	// ------------------------------------------------------------------
	// Divide steps. Stage 0 holds the prepared operands, stage k holds the
	// state after k quotient bits. Narrow operands are zero-extended, so the
	// leading steps just produce zero bits (or ones for a zero divisor,
	// which the output mask trims).
	// ------------------------------------------------------------------
	stage_t         stg_s [0:DIV_W];
	logic           vld_s [0:DIV_W];
	stage_t         nxt   [0:DIV_W-1];
	logic [DIV_W:0] trial [0:DIV_W-1];
	logic [DIV_W:0] diff  [0:DIV_W-1];

	always_comb begin
		for (int k = 0; k < DIV_W; k++) begin
			trial[k] = {stg_s[k].rem, stg_s[k].qa[DIV_W-1]};
			diff[k]  = trial[k] - {1'b0, stg_s[k].dsor};
			nxt[k]   = stg_s[k];
			// no borrow: keep the difference, quotient bit is one
			nxt[k].rem = diff[k][DIV_W] ? trial[k][DIV_W-1:0] : diff[k][DIV_W-1:0];
			nxt[k].qa  = {stg_s[k].qa[DIV_W-2:0], ~diff[k][DIV_W]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DIV_W; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (advance) begin
			vld_s[0] <= req_valid;
			for (int k = 0; k < DIV_W; k++) begin
				vld_s[k+1] <= vld_s[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			stg_s[0] <= prep;
			for (int k = 0; k < DIV_W; k++) begin
				stg_s[k+1] <= nxt[k];
			end
		end
	end

	// ------------------------------------------------------------------
	// Sign fix-up: quotient negated when the signs differ, remainder
	// takes the sign of the dividend; mask to the selected width.
	// ------------------------------------------------------------------
	logic [DIV_W-1:0] msk_fin;
	logic [DIV_W-1:0] q_mag;
	logic [DIV_W-1:0] r_mag;
	logic [DIV_W-1:0] q_fix;
	logic [DIV_W-1:0] r_fix;
	div_rsp_t         fin;
	logic             fin_valid;

	assign msk_fin   = stg_s[DIV_W].wide ? MASK_WIDE : MASK_NARROW;
	assign q_mag     = stg_s[DIV_W].qa;
	assign r_mag     = stg_s[DIV_W].rem;
	assign q_fix     = (stg_s[DIV_W].neg_q ? (~q_mag + DIV_W'(1)) : q_mag) & msk_fin;
	assign r_fix     = (stg_s[DIV_W].neg_r ? (~r_mag + DIV_W'(1)) : r_mag) & msk_fin;
	assign fin_valid = vld_s[DIV_W];

	always_comb begin
		fin                = '0;
		fin.quotient       = FIELD_W'(q_fix);
		fin.remainder      = FIELD_W'(r_fix);
		fin.divide_by_zero = stg_s[DIV_W].dbz;
	end

	// ------------------------------------------------------------------
	// Output register plus skid entry. The skid catches the one response
	// that leaves the pipe while the output is stalled; once it is full
	// the pipe freezes and requests are held off.
	// ------------------------------------------------------------------
	logic     out_vld_q;
	div_rsp_t out_q;
	logic     skid_vld_q;
	div_rsp_t skid_q;

	assign advance   = !skid_vld_q;
	assign req_ready = advance;
	assign rsp_valid = out_vld_q;
	assign rsp       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (rsp_ready) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end
		end else if (out_vld_q && !rsp_ready) begin
			skid_vld_q <= fin_valid;
		end else begin
			out_vld_q <= fin_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (rsp_ready) begin
				out_q <= skid_q;
			end
		end else if (out_vld_q && !rsp_ready) begin
			skid_q <= fin;
		end else begin
			out_q <= fin;
		end
	end

endmodule

`default_nettype wire

FILE: tb/tb_restoring_integer_divider.sv
// Self-checking testbench for the restoring integer divider: directed and random requests.
module tb_restoring_integer_divider;
	timeunit 1ns;
	timeprecision 1ps;

	import rid_pkg::*;

	// Cycles with no accepted request or response before the run is declared hung.
	// The long receiver hold-off below is the slowest stretch of a correct run.
	localparam int STALL_LIMIT  = 4000;
	// Random request count; directed requests come on top.
	localparam int RAND_ITEMS   = 1100;
	// Random request index at which the sender drains the block before going on.
	localparam int PAUSE_AT     = 300;
	// Random request index at which the receiver starts its long hold-off.
	localparam int HOLD_AT      = 550;
	localparam int HOLD_CYCLES  = 400;
	// Tail at the end: wait well past the pipeline depth from the header.
	localparam int TAIL_CYCLES  = 2 * (DIV_W + 1);
	localparam int MAX_SHOWN    = 10;

	// Scoreboard: predicts each accepted request, checks responses in order.
	class div_scoreboard;
		div_rsp_t results_due[$];
		int       errors;

		function new();
			errors = 0;
		endfunction

		// Bit-serial restoring division at the width the mode selects.
		function div_rsp_t divide_restoring(div_req_t r);
			div_rsp_t         res;
			logic [FIELD_W-1:0] m;
			logic [FIELD_W-1:0] a;
			logic [FIELD_W-1:0] b;
			logic [FIELD_W-1:0] q;
			logic [FIELD_W-1:0] rem;
			int               w;
			int               i;
			bit               wide;
			bit               sgn;
			bit               neg_a;
			bit               neg_b;
			bit               carry;
			wide  = (r.mode == MODE_U_WIDE) || (r.mode == MODE_S_WIDE);
			sgn   = (r.mode == MODE_S_NARROW) || (r.mode == MODE_S_WIDE);
			w     = wide ? DIV_W : HALF_W;
			m     = wide ? FIELD_W'(MASK_WIDE) : FIELD_W'(MASK_NARROW);
			a     = r.dividend & m;
			b     = r.divisor & m;
			neg_a = 1'b0;
			neg_b = 1'b0;
			if (sgn) begin
				// work on magnitudes; the most negative value maps to itself
				neg_a = a[w-1];
				neg_b = b[w-1];
				if (neg_a) a = (~a + 1'b1) & m;
				if (neg_b) b = (~b + 1'b1) & m;
			end
			q   = '0;
			rem = '0;
			for (i = w - 1; i >= 0; i--) begin
				// the bit shifted out counts as part of the partial remainder
				carry = rem[w-1];
				rem   = ((rem << 1) | FIELD_W'(a[i])) & m;
				if (carry || rem >= b) begin
					rem  = (rem - b) & m;
					q[i] = 1'b1;
				end
			end
			if (sgn) begin
				if (neg_a != neg_b) q = (~q + 1'b1) & m;
				if (neg_a) rem = (~rem + 1'b1) & m;
			end
			res.quotient       = q & m;
			res.remainder      = rem & m;
			res.divide_by_zero = (b == '0);
			return res;
		endfunction

		function void note_request(div_req_t r);
			results_due.push_back(divide_restoring(r));
		endfunction

		function void flag(string field, logic [FIELD_W-1:0] want, logic [FIELD_W-1:0] got);
			errors++;
			if (errors <= MAX_SHOWN)
				$display("%0t mismatch on %s: expected %h, got %h", $realtime, field, want, got);
		endfunction

		function void check_response(div_rsp_t got);
			div_rsp_t want;
			if (results_due.size() == 0) begin
				errors++;
				if (errors <= MAX_SHOWN)
					$display("%0t response with none pending: q=%h r=%h z=%b", $realtime,
						got.quotient, got.remainder, got.divide_by_zero);
				return;
			end
			want = results_due.pop_front();
			if (got.quotient !== want.quotient)
				flag("quotient", want.quotient, got.quotient);
			if (got.remainder !== want.remainder)
				flag("remainder", want.remainder, got.remainder);
			if (got.divide_by_zero !== want.divide_by_zero)
				flag("divide_by_zero", FIELD_W'(want.divide_by_zero),
					FIELD_W'(got.divide_by_zero));
		endfunction

		function int pending();
			return results_due.size();
		endfunction
	endclass

	logic     clk;
	logic     arst_n;
	logic     req_valid;
	logic     req_ready;
	div_req_t req;
	logic     rsp_valid;
	logic     rsp_ready;
	div_rsp_t rsp;

	div_scoreboard sb = new();

	// Set by the sender once; the receiver picks it up and holds off.
	bit hold_go = 1'b0;
	int idle_count = 0;

	restoring_integer_divider u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Monitor: at each rising edge the sampled handshake values are the ones
	// from before the edge, since all drivers use nonblocking updates.
	// Also the hang watchdog: counts edges where neither channel moves.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready)
				sb.note_request(req);
			if (rsp_valid && rsp_ready)
				sb.check_response(rsp);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				idle_count <= 0;
			else
				idle_count <= idle_count + 1;
			if (idle_count >= STALL_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles, %0d responses pending",
					idle_count, sb.pending());
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Offer one request and hold it until accepted. Leaves valid high so a
	// following request in the same burst goes out on the next edge.
	task automatic send_request(div_req_t r);
		req_valid <= 1'b1;
		req       <= r;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
	endtask

	// Gap in the request stream; zero means no gap.
	task automatic idle_cycles(int n);
		if (n > 0) begin
			req_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Stop offering until every predicted response has come back.
	task automatic drain_wait();
		req_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() > 0) @(posedge clk);
	endtask

	// Operand mix: small values, near-max, sign boundaries at both widths,
	// shifted random magnitudes, zero, and plain 64-bit noise.
	function automatic logic [FIELD_W-1:0] rand_operand();
		logic [FIELD_W-1:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 11))
			0, 1: v = FIELD_W'($urandom_range(0, 15));
			2, 3: v = v >> $urandom_range(0, FIELD_W - 1);
			4:    v = ~FIELD_W'($urandom_range(0, 7));
			5:    v = {1'b1, {(FIELD_W-1){1'b0}}} + FIELD_W'($urandom_range(0, 3));
			6:    v = {v[FIELD_W-1:HALF_W], 1'b1, {(HALF_W-1){1'b0}}};
			7:    v = {v[FIELD_W-1:HALF_W], {HALF_W{1'b1}}};
			8:    v = '0;
			default: ;
		endcase
		return v;
	endfunction

	function automatic div_req_t rand_request();
		div_req_t r;
		r.mode     = 2'($urandom_range(MODE_U_NARROW, MODE_S_WIDE));
		r.dividend = rand_operand();
		r.divisor  = rand_operand();
		return r;
	endfunction

	// Receiver: segments of always-ready, coin-flip, mostly-stalled and a
	// fixed two-in-three pattern; one long hold-off when the sender asks.
	initial begin
		int kind;
		int len;
		int k;
		rsp_ready = 1'b0;
		wait (arst_n);
		forever begin
			if (hold_go) begin
				hold_go = 1'b0;
				@(posedge clk);
				rsp_ready <= 1'b0;
				for (k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
			end else begin
				kind = $urandom_range(0, 3);
				len  = $urandom_range(4, 60);
				for (k = 0; k < len; k++) begin
					@(posedge clk);
					case (kind)
						0: rsp_ready <= 1'b1;
						1: rsp_ready <= 1'($urandom_range(0, 1));
						2: rsp_ready <= ($urandom_range(0, 3) == 0);
						default: rsp_ready <= (k % 3 != 0);
					endcase
				end
			end
		end
	end

	// Sender: reset, directed corner requests, then random bursts.
	initial begin
		int n;
		int burst_left;
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Narrow unsigned: junk in the upper half must be ignored, zero divisor,
		// divisor at the top of the range.
		send_request(div_req_t'{MODE_U_NARROW, 64'hFFFF_FFFF_FFFF_FFFF, 64'hABCD_0000_0000_0001});
		send_request(div_req_t'{MODE_U_NARROW, 64'h0000_0000_0000_0007, 64'h0000_0000_0000_0000});
		send_request(div_req_t'{MODE_U_NARROW, 64'h0000_0000_1234_5678, 64'h0000_0000_0000_0009});
		send_request(div_req_t'{MODE_U_NARROW, 64'h0000_0000_0000_0005, 64'h0000_0000_FFFF_FFFF});
		// Narrow signed: most negative by minus one wraps; mixed and both-negative signs;
		// zero divisor with negative and with zero dividend.
		send_request(div_req_t'{MODE_S_NARROW, 64'h0000_0000_8000_0000, 64'h0000_0000_FFFF_FFFF});
		send_request(div_req_t'{MODE_S_NARROW, 64'h0000_0000_FFFF_FFF9, 64'h0000_0000_0000_0002});
		send_request(div_req_t'{MODE_S_NARROW, 64'h0000_0000_0000_0007, 64'hFFFF_FFFF_FFFF_FFFE});
		send_request(div_req_t'{MODE_S_NARROW, 64'hFFFF_FFFF_FFFF_FFF9, 64'h0000_0000_FFFF_FFFE});
		send_request(div_req_t'{MODE_S_NARROW, 64'h0000_0000_FFFF_FFFB, 64'hFFFF_FFFF_0000_0000});
		send_request(div_req_t'{MODE_S_NARROW, 64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000});
		// Wide unsigned: extremes of both operands, zero divisor.
		send_request(div_req_t'{MODE_U_WIDE, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001});
		send_request(div_req_t'{MODE_U_WIDE, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF});
		send_request(div_req_t'{MODE_U_WIDE, 64'h0000_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF});
		send_request(div_req_t'{MODE_U_WIDE, 64'h0000_0000_0000_3039, 64'h0000_0000_0000_0000});
		send_request(div_req_t'{MODE_U_WIDE, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000});
		// Wide signed: wrap case, sign combinations, zero divisor, max by min.
		send_request(div_req_t'{MODE_S_WIDE, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF});
		send_request(div_req_t'{MODE_S_WIDE, 64'hFFFF_FFFF_FFFF_FFF9, 64'h0000_0000_0000_0002});
		send_request(div_req_t'{MODE_S_WIDE, 64'h0000_0000_0000_0007, 64'hFFFF_FFFF_FFFF_FFFE});
		send_request(div_req_t'{MODE_S_WIDE, 64'hFFFF_FFFF_FFFF_FFF9, 64'hFFFF_FFFF_FFFF_FFFE});
		send_request(div_req_t'{MODE_S_WIDE, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000});
		send_request(div_req_t'{MODE_S_WIDE, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000});
		send_request(div_req_t'{MODE_S_WIDE, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000});
		drain_wait();

		burst_left = 0;
		for (n = 0; n < RAND_ITEMS; n++) begin
			// one full drain in the middle of the random part
			if (n == PAUSE_AT)
				drain_wait();
			// long receiver hold-off with back-to-back requests so the
			// pipeline and skid fill and req_ready drops
			if (n == HOLD_AT) begin
				hold_go    = 1'b1;
				burst_left = 250;
			end
			if (burst_left == 0) begin
				idle_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
				burst_left = $urandom_range(1, 40);
			end
			send_request(rand_request());
			burst_left--;
		end
		req_valid <= 1'b0;
		@(posedge clk);

		// Wait out outstanding responses (watchdog covers a hang), then a tail
		// to catch any stray extra response.
		while (sb.pending() > 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (sb.pending() > 0)
			$display("%0d responses never arrived", sb.pending());
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

FILE: sim.f
sv/rid_pkg.sv
sv/restoring_integer_divider.sv
tb/tb_restoring_integer_divider.sv
